FILE: hdl/cdr_pkg.sv
`default_nettype none

package cdr_pkg;

  // Operation codes of an input transaction. Code 7 is unused and rejected.
  localparam logic [2:0] OP_SET_DATE   = 3'd0;
  localparam logic [2:0] OP_SET_DAY    = 3'd1;
  localparam logic [2:0] OP_SET_MONTH  = 3'd2;
  localparam logic [2:0] OP_SET_YEAR   = 3'd3;
  localparam logic [2:0] OP_ADD_DAYS   = 3'd4;
  localparam logic [2:0] OP_ADD_MONTHS = 3'd5;
  localparam logic [2:0] OP_ADD_YEARS  = 3'd6;

  // Datapath action of one microinstruction.
  typedef enum logic [3:0] {
    A_NOP,
    A_LD_SET,
    A_LD_DAYS,
    A_LD_MONTHS,
    A_LD_YEARS,
    A_DIV12,
    A_REM12,
    A_MSTEP,
    A_YSTEP,
    A_CLAMP,
    A_FEB,
    A_COMMIT,
    A_SAT,
    A_REJECT
  } act_e;

  // Branch condition of one microinstruction.
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_YOVF,
    C_BADSET,
    C_DFITS,
    C_YSKIP,
    C_NWRAP
  } cond_e;

  // Status the datapath reports to the sequencer.
  typedef struct packed {
    logic yovf;
    logic badset;
    logic dfits;
    logic yskip;
    logic wrap;
  } cdr_flags_t;

endpackage

`default_nettype wire

FILE: hdl/calendar_date_register.sv
// Calendar date register: holds one Gregorian date, 01/01/2000 after reset.
// Input channel (in_valid_i / in_ready_o) carries one transaction with an
// op code, the set values new_day/new_month/new_year and an add amount.
// Output channel (out_valid_o / out_ready_i) returns one transaction per
// input: the date after the operation and ok.
// A short microprogram runs each item over a plain datapath. A saturating
// add ends as soon as the year passes its limit. The add-days carry loop,
// one month or one year per pass, makes add days the slowest operation.
// A new item is taken in the cycle after the previous one finishes, even
// while its result still waits in the output register.
// A stalled receiver holds the result stable; the next item then halts at
// its final step until the output register is free.
// Reset is asynchronous and active low: the date becomes 01/01/2000, the
// output channel empties and the sequencer goes idle.
`default_nettype none

module calendar_date_register #(
  parameter int MAX_YEAR    = 9999,
  parameter int AMOUNT_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  op_i,
  input  wire  [4:0]  new_day_i,
  input  wire  [3:0]  new_month_i,
  input  wire  [13:0] new_year_i,
  input  wire  [15:0] amount_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [4:0]  cur_day_o,
  output logic [3:0]  cur_month_o,
  output logic [13:0] cur_year_o,
  output logic        ok_o
);

  // Only the low AMOUNT_BITS bits, at most 16, of the amount port count.
  localparam int AmtW = (AMOUNT_BITS < 16) ? AMOUNT_BITS : 16;
  // Work day register holds day + amount, or month - 1 + amount.
  localparam int WdW  = ((AmtW > 5) ? AmtW : 5) + 1;
  localparam int WqW  = WdW - 3;
  // Work year register holds year + amount.
  localparam int WyW  = ((AmtW > 14) ? AmtW : 14) + 1;
  localparam int XW   = (WdW > 9) ? WdW : 9;
  localparam int PW   = WdW + 16;
  // floor(t / 12) == (t * 43691) >> 19 for every t below 2^17.
  localparam int Recip12   = 43691;
  localparam int Recip12Sh = 19;
  localparam int DaysInYear = 365;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Leap test on a year below 16384. floor(y / 100) comes from a reciprocal
  // multiply; y is a multiple of 400 when it is a multiple of 100 and the
  // quotient is a multiple of 4.
  function automatic logic leap_of(input logic [13:0] y);
    logic [27:0] p;
    logic [7:0]  q;
    logic [14:0] hq;
    logic [14:0] r;
    p  = {14'd0, y} * 28'd10486;
    q  = p[27:20];
    hq = {7'd0, q} * 15'd100;
    r  = {1'b0, y} - hq;
    return (y[1:0] == 2'b00) && ((r != 15'd0) || (q[1:0] == 2'b00));
  endfunction

  // Architectural date and result flag. The output channel shows them
  // directly: they change only when the output register is being refilled.
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;
  logic        ok_q;
  logic        out_valid_q, out_valid_d;

  // Captured transaction.
  logic [2:0]      op_q;
  logic [4:0]      nd_q;
  logic [3:0]      nm_q;
  logic [13:0]     ny_q;
  logic [AmtW-1:0] amt_q;

  // Work registers.
  logic [WdW-1:0] wd_q, wd_d;
  logic [3:0]     wm_q, wm_d;
  logic [WyW-1:0] wy_q, wy_d;
  logic [WqW-1:0] wq_q, wq_d;
  logic           leap_q;

  logic                busy;
  logic                accept;
  cdr_pkg::act_e       act;
  cdr_pkg::cdr_flags_t flags;

  logic [4:0]     len_w;
  logic [4:0]     set_day;
  logic [3:0]     set_month;
  logic [13:0]    set_year;
  logic [PW-1:0]  prod12;
  logic [WdW-1:0] rem12;
  logic [XW-1:0]  year_len;
  logic [XW-1:0]  ystep;
  logic [4:0]     clamp_day;
  logic [4:0]     feb_day;
  logic           fin_act;

  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  cdr_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .op_i       (op_i),
    .flags_i    (flags),
    .out_free_i (!out_valid_q || out_ready_i),
    .busy_o     (busy),
    .act_o      (act)
  );

  // Status for branching. The leap flag is registered from the work year and
  // so lags it; the microprogram waits a step after every load of a new year.
  assign len_w       = month_len(wm_q, leap_q);
  assign flags.yovf  = wy_q > WyW'(MAX_YEAR);
  assign flags.dfits = wd_q <= WdW'(len_w);
  assign flags.wrap  = wm_q == 4'd12;
  assign year_len    = XW'(DaysInYear) + XW'(leap_q);
  // From January, a day count beyond the year's length crosses the whole year.
  assign flags.yskip = (wm_q == 4'd1) && (XW'(wd_q) > year_len);
  assign flags.badset = flags.yovf || (wm_q == 4'd0) || (wm_q > 4'd12) ||
                        (wd_q == '0) || !flags.dfits;

  // Operands of the set operations: new parts merged with the current date.
  always_comb begin
    set_day   = day_q;
    set_month = month_q;
    set_year  = year_q;
    case (op_q)
      cdr_pkg::OP_SET_DATE: begin
        set_day   = nd_q;
        set_month = nm_q;
        set_year  = ny_q;
      end
      cdr_pkg::OP_SET_DAY:   set_day   = nd_q;
      cdr_pkg::OP_SET_MONTH: set_month = nm_q;
      cdr_pkg::OP_SET_YEAR:  set_year  = ny_q;
      default: ;
    endcase
  end

  assign prod12    = PW'(wd_q) * PW'(Recip12);
  assign rem12     = wd_q - WdW'({wq_q, 3'b000}) - WdW'({wq_q, 2'b00});
  assign ystep     = XW'(wd_q) - year_len;
  assign clamp_day = (day_q > len_w) ? len_w : day_q;
  assign feb_day   = ((month_q == 4'd2) && (day_q == 5'd29) && !leap_q) ? 5'd28 : day_q;

  always_comb begin
    wd_d = wd_q;
    wm_d = wm_q;
    wy_d = wy_q;
    wq_d = wq_q;
    case (act)
      cdr_pkg::A_LD_SET: begin
        wd_d = WdW'(set_day);
        wm_d = set_month;
        wy_d = WyW'(set_year);
      end
      cdr_pkg::A_LD_DAYS: begin
        wd_d = WdW'(day_q) + WdW'(amt_q);
        wm_d = month_q;
        wy_d = WyW'(year_q);
      end
      cdr_pkg::A_LD_MONTHS: begin
        // Months counted from zero so that the quotient by 12 is the year carry.
        wd_d = WdW'(month_q) - WdW'(1) + WdW'(amt_q);
        wy_d = WyW'(year_q);
      end
      cdr_pkg::A_LD_YEARS: begin
        wy_d = WyW'(year_q) + WyW'(amt_q);
      end
      cdr_pkg::A_DIV12: wq_d = prod12[PW-1:Recip12Sh];
      cdr_pkg::A_REM12: begin
        wm_d = rem12[3:0] + 4'd1;
        wy_d = wy_q + WyW'(wq_q);
      end
      cdr_pkg::A_MSTEP: begin
        wd_d = wd_q - WdW'(len_w);
        if (wm_q == 4'd12) begin
          wm_d = 4'd1;
          wy_d = wy_q + WyW'(1);
        end else begin
          wm_d = wm_q + 4'd1;
        end
      end
      cdr_pkg::A_YSTEP: begin
        wd_d = ystep[WdW-1:0];
        wy_d = wy_q + WyW'(1);
      end
      cdr_pkg::A_CLAMP: wd_d = WdW'(clamp_day);
      cdr_pkg::A_FEB: begin
        wd_d = WdW'(feb_day);
        wm_d = month_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      nd_q  <= new_day_i;
      nm_q  <= new_month_i;
      ny_q  <= new_year_i;
      amt_q <= amount_i[AmtW-1:0];
    end
    wd_q   <= wd_d;
    wm_q   <= wm_d;
    wy_q   <= wy_d;
    wq_q   <= wq_d;
    leap_q <= leap_of(wy_q[13:0]);
  end

  assign fin_act = (act == cdr_pkg::A_COMMIT) || (act == cdr_pkg::A_SAT) ||
                   (act == cdr_pkg::A_REJECT);
  assign out_valid_d = fin_act ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q       <= 5'd1;
      month_q     <= 4'd1;
      year_q      <= 14'd2000;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (act)
        cdr_pkg::A_COMMIT: begin
          day_q   <= wd_q[4:0];
          month_q <= wm_q;
          year_q  <= wy_q[13:0];
          ok_q    <= 1'b1;
        end
        cdr_pkg::A_SAT: begin
          // The year ran past its limit: pin the date to the last day.
          day_q   <= 5'd31;
          month_q <= 4'd12;
          year_q  <= 14'(MAX_YEAR);
          ok_q    <= 1'b0;
        end
        cdr_pkg::A_REJECT: ok_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cur_day_o   = day_q;
  assign cur_month_o = month_q;
  assign cur_year_o  = year_q;
  assign ok_o        = ok_q;

endmodule

`default_nettype wire

FILE: hdl/cdr_sequencer.sv
`default_nettype none

module cdr_sequencer (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire  [2:0]        op_i,
  input  wire  cdr_pkg::cdr_flags_t flags_i,
  input  wire               out_free_i,
  output logic              busy_o,
  output cdr_pkg::act_e     act_o
);

  typedef struct packed {
    cdr_pkg::act_e  act;
    cdr_pkg::cond_e cond;
    logic [4:0]     target;
  } uword_t;

  // Program entry points, loop targets and shared exits.
  localparam logic [4:0] PcSet    = 5'd0;
  localparam logic [4:0] PcCommit = 5'd3;
  localparam logic [4:0] PcDays   = 5'd4;
  localparam logic [4:0] PcDLoop  = 5'd6;
  localparam logic [4:0] PcDWrap  = 5'd9;
  localparam logic [4:0] PcDYear  = 5'd11;
  localparam logic [4:0] PcMonths = 5'd12;
  localparam logic [4:0] PcYears  = 5'd17;
  localparam logic [4:0] PcSat    = 5'd20;
  localparam logic [4:0] PcRej    = 5'd21;

  function automatic uword_t rom(input logic [4:0] pc);
    uword_t w;
    w = '{act: cdr_pkg::A_NOP, cond: cdr_pkg::C_NONE, target: 5'd0};
    case (pc)
      // set date or one part of it
      5'd0:  w.act = cdr_pkg::A_LD_SET;
      5'd1:  w.act = cdr_pkg::A_NOP;
      5'd2:  begin w.cond = cdr_pkg::C_BADSET; w.target = PcRej; end
      5'd3:  w.act = cdr_pkg::A_COMMIT;
      // add days: carry one month, or one whole year from January, per pass
      5'd4:  w.act = cdr_pkg::A_LD_DAYS;
      5'd5:  begin w.cond = cdr_pkg::C_YOVF; w.target = PcSat; end
      5'd6:  begin w.cond = cdr_pkg::C_DFITS; w.target = PcCommit; end
      5'd7:  begin w.cond = cdr_pkg::C_YSKIP; w.target = PcDYear; end
      5'd8:  begin
        w.act = cdr_pkg::A_MSTEP; w.cond = cdr_pkg::C_NWRAP; w.target = PcDLoop;
      end
      5'd9:  begin w.cond = cdr_pkg::C_YOVF; w.target = PcSat; end
      5'd10: begin w.cond = cdr_pkg::C_ALWAYS; w.target = PcDLoop; end
      5'd11: begin
        w.act = cdr_pkg::A_YSTEP; w.cond = cdr_pkg::C_ALWAYS; w.target = PcDWrap;
      end
      // add months
      5'd12: w.act = cdr_pkg::A_LD_MONTHS;
      5'd13: w.act = cdr_pkg::A_DIV12;
      5'd14: w.act = cdr_pkg::A_REM12;
      5'd15: begin w.cond = cdr_pkg::C_YOVF; w.target = PcSat; end
      5'd16: begin
        w.act = cdr_pkg::A_CLAMP; w.cond = cdr_pkg::C_ALWAYS; w.target = PcCommit;
      end
      // add years
      5'd17: w.act = cdr_pkg::A_LD_YEARS;
      5'd18: begin w.cond = cdr_pkg::C_YOVF; w.target = PcSat; end
      5'd19: begin
        w.act = cdr_pkg::A_FEB; w.cond = cdr_pkg::C_ALWAYS; w.target = PcCommit;
      end
      5'd20: w.act = cdr_pkg::A_SAT;
      5'd21: w.act = cdr_pkg::A_REJECT;
      default: w.act = cdr_pkg::A_REJECT;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] entry(input logic [2:0] op);
    logic [4:0] pc;
    case (op)
      cdr_pkg::OP_SET_DATE,
      cdr_pkg::OP_SET_DAY,
      cdr_pkg::OP_SET_MONTH,
      cdr_pkg::OP_SET_YEAR:   pc = PcSet;
      cdr_pkg::OP_ADD_DAYS:   pc = PcDays;
      cdr_pkg::OP_ADD_MONTHS: pc = PcMonths;
      cdr_pkg::OP_ADD_YEARS:  pc = PcYears;
      default:                pc = PcRej;
    endcase
    return pc;
  endfunction

  logic [4:0] pc_q, pc_d;
  logic       busy_q, busy_d;
  uword_t     uw;
  logic       fin;
  logic       take;

  assign uw  = rom(pc_q);
  assign fin = (uw.act == cdr_pkg::A_COMMIT) || (uw.act == cdr_pkg::A_SAT) ||
               (uw.act == cdr_pkg::A_REJECT);

  always_comb begin
    case (uw.cond)
      cdr_pkg::C_ALWAYS: take = 1'b1;
      cdr_pkg::C_YOVF:   take = flags_i.yovf;
      cdr_pkg::C_BADSET: take = flags_i.badset;
      cdr_pkg::C_DFITS:  take = flags_i.dfits;
      cdr_pkg::C_YSKIP:  take = flags_i.yskip;
      cdr_pkg::C_NWRAP:  take = !flags_i.wrap;
      default:           take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    act_o  = cdr_pkg::A_NOP;
    if (!busy_q) begin
      if (start_i) begin
        pc_d   = entry(op_i);
        busy_d = 1'b1;
      end
    end else if (fin) begin
      // A finishing step waits until the output register is free.
      if (out_free_i) begin
        act_o  = uw.act;
        busy_d = 1'b0;
      end
    end else begin
      act_o = uw.act;
      pc_d  = take ? uw.target : pc_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= 5'd0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire
